// ----- rtl/fpa_pkg.sv -----
// Shared types and constants of the fixed-point ALU.
package fpa_pkg;

  typedef enum logic [3:0] {
    ACT_ADD      = 4'd0,
    ACT_SUB      = 4'd1,
    ACT_MUL      = 4'd2,
    ACT_DIV      = 4'd3,
    ACT_COMPARE  = 4'd4,
    ACT_MIN      = 4'd5,
    ACT_MAX      = 4'd6,
    ACT_INC      = 4'd7,
    ACT_DEC      = 4'd8,
    ACT_TO_INT   = 4'd9,
    ACT_FROM_INT = 4'd10
  } action_t;

  // How the back end finishes a request.
  typedef enum logic [1:0] {
    KIND_SIMPLE = 2'd0,
    KIND_MUL    = 2'd1,
    KIND_DIV    = 2'd2
  } kind_t;

  localparam logic [31:0] DIVZ_SENTINEL = -32'sd8388610;

  typedef struct packed {
    logic gt;
    logic lt;
    logic eq;
    logic dz;
  } flags_t;

  // One classified request as it waits in the queue.
  typedef struct packed {
    kind_t       kind;
    logic [31:0] res;
    flags_t      flg;
    logic [31:0] a;
    logic [31:0] b;
  } entry_t;

endpackage

// ----- rtl/fpa_if.sv -----
// Valid/ready channel interfaces for requests and results.
interface fpa_in_if;
  logic               valid;
  logic               ready;
  logic [3:0]         action;
  logic signed [31:0] operand_a;
  logic signed [31:0] operand_b;

  modport source (output valid, output action, output operand_a, output operand_b,
                  input ready);
  modport sink   (input valid, input action, input operand_a, input operand_b,
                  output ready);
endinterface

interface fpa_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_value;
  logic               a_greater;
  logic               a_less;
  logic               a_equal;
  logic               divide_by_zero;

  modport source (output valid, output result_value, output a_greater, output a_less,
                  output a_equal, output divide_by_zero, input ready);
  modport sink   (input valid, input result_value, input a_greater, input a_less,
                  input a_equal, input divide_by_zero, output ready);
endinterface

// ----- rtl/fpa_front.sv -----
// Front end: decodes a request, computes flags and the results that need no multiply or divide.
module fpa_front #(
  parameter int FRAC_BITS = 8
) (
  input  logic [3:0]      action,
  input  logic [31:0]     operand_a,
  input  logic [31:0]     operand_b,
  output fpa_pkg::entry_t entry
);
  import fpa_pkg::*;

  localparam logic [31:0] SENT_SHIFTED = DIVZ_SENTINEL << FRAC_BITS;

  logic gt, lt, eq;

  always_comb begin
    gt = $signed(operand_a) > $signed(operand_b);
    lt = $signed(operand_a) < $signed(operand_b);
    eq = operand_a == operand_b;

    entry.kind    = KIND_SIMPLE;
    entry.res     = '0;
    entry.flg.gt  = gt;
    entry.flg.lt  = lt;
    entry.flg.eq  = eq;
    entry.flg.dz  = 1'b0;
    entry.a       = operand_a;
    entry.b       = operand_b;

    case (action)
      ACT_ADD:      entry.res = operand_a + operand_b;
      ACT_SUB:      entry.res = operand_a - operand_b;
      ACT_MUL:      entry.kind = KIND_MUL;
      ACT_DIV: begin
        if (operand_b == '0) begin
          entry.flg.dz = 1'b1;
          entry.res    = SENT_SHIFTED;
        end else begin
          entry.kind = KIND_DIV;
        end
      end
      ACT_MIN:      entry.res = (lt || eq) ? operand_a : operand_b;
      ACT_MAX:      entry.res = (gt || eq) ? operand_a : operand_b;
      ACT_INC:      entry.res = operand_a + 32'd1;
      ACT_DEC:      entry.res = operand_a - 32'd1;
      ACT_TO_INT:   entry.res = 32'($signed(operand_a) >>> FRAC_BITS);
      ACT_FROM_INT: entry.res = operand_a << FRAC_BITS;
      default:      entry.res = '0;
    endcase
  end
endmodule

// ----- rtl/fpa_queue.sv -----
// Four-entry request queue between front and back ends.
module fpa_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  fpa_pkg::entry_t push_entry,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output fpa_pkg::entry_t head_entry
);
  import fpa_pkg::*;

  entry_t     mem_r [4];
  logic [1:0] wr_ptr_r, rd_ptr_r;
  logic [2:0] cnt_r;
  logic       do_push, do_pop;

  assign full       = cnt_r == 3'd4;
  assign head_valid = cnt_r != 3'd0;
  assign head_entry = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 2'd1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 2'd1;
      cnt_r <= cnt_r + {2'b0, do_push} - {2'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_entry;
  end
endmodule

// ----- rtl/fpa_back.sv -----
// Back end: multiply stage, one-bit-per-stage divider and output register.
module fpa_back #(
  parameter int FRAC_BITS = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            head_valid,
  input  fpa_pkg::entry_t head_entry,
  output logic            pop,
  fpa_out_if.source       out_ch
);
  import fpa_pkg::*;

  localparam int N = 32 + FRAC_BITS;

  typedef struct packed {
    kind_t        kind;
    logic [31:0]  res;
    flags_t       flg;
    logic         neg;
    logic [31:0]  d;
    logic [31:0]  rem;
    logic [N-1:0] nq;
  } stage_t;

  stage_t             st_r   [N+1];
  stage_t             st_nxt [N+1];
  logic [N:0]         valid_r;
  logic signed [63:0] prod_r;
  logic               adv;
  logic               out_valid_r;
  logic [31:0]        res_r;
  flags_t             flg_r;
  logic [31:0]        abs_a, abs_b, q, div_res;
  logic [32:0]        rem_ext, diff;

  // Hold the whole pipe while the output register is blocked.
  assign adv = !out_valid_r || out_ch.ready;
  assign pop = adv && head_valid;

  always_comb begin
    abs_a = head_entry.a[31] ? -head_entry.a : head_entry.a;
    abs_b = head_entry.b[31] ? -head_entry.b : head_entry.b;
    st_nxt[0].kind = head_entry.kind;
    st_nxt[0].res  = head_entry.res;
    st_nxt[0].flg  = head_entry.flg;
    st_nxt[0].neg  = head_entry.a[31] ^ head_entry.b[31];
    st_nxt[0].d    = abs_b;
    st_nxt[0].rem  = '0;
    st_nxt[0].nq   = {abs_a, {FRAC_BITS{1'b0}}};

    rem_ext = '0;
    diff    = '0;
    for (int i = 1; i <= N; i++) begin
      rem_ext   = {st_r[i-1].rem, st_r[i-1].nq[N-1]};
      diff      = rem_ext - {1'b0, st_r[i-1].d};
      st_nxt[i] = st_r[i-1];
      if (!diff[32]) begin
        st_nxt[i].rem = diff[31:0];
        st_nxt[i].nq  = {st_r[i-1].nq[N-2:0], 1'b1};
      end else begin
        st_nxt[i].rem = rem_ext[31:0];
        st_nxt[i].nq  = {st_r[i-1].nq[N-2:0], 1'b0};
      end
    end

    // Fold the product down on its way through the first step.
    if (st_r[0].kind == KIND_MUL) begin
      st_nxt[1].res = prod_r[FRAC_BITS+31:FRAC_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (adv) begin
      valid_r <= {valid_r[N-1:0], head_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_r   <= st_nxt;
      prod_r <= $signed(head_entry.a) * $signed(head_entry.b);
    end
  end

  assign q       = st_r[N].nq[31:0];
  assign div_res = st_r[N].neg ? -q : q;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= valid_r[N];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= (st_r[N].kind == KIND_DIV) ? div_res : st_r[N].res;
      flg_r <= st_r[N].flg;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.result_value   = res_r;
  assign out_ch.a_greater      = flg_r.gt;
  assign out_ch.a_less         = flg_r.lt;
  assign out_ch.a_equal        = flg_r.eq;
  assign out_ch.divide_by_zero = flg_r.dz;
endmodule

// ----- rtl/fixed_point_alu.sv -----
// Signed 32-bit fixed-point ALU with FRAC_BITS fraction bits. It takes one request per
// cycle while the queue is not full and returns one result per request, in order. Every
// result, once its request is taken, passes through the four-entry queue, the multiply
// stage, the divider that settles one quotient bit per stage, and the output register;
// all actions share that path so order holds.
// A stalled output holds the whole back end; the queue keeps taking requests until full.
module fixed_point_alu #(
  parameter int FRAC_BITS = 8
) (
  input  logic     clk,
  input  logic     rst_n,
  fpa_in_if.sink   in_ch,
  fpa_out_if.source out_ch
);
  import fpa_pkg::*;

  entry_t entry, head_entry;
  logic   full, head_valid, pop;

  fpa_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .action    (in_ch.action),
    .operand_a (in_ch.operand_a),
    .operand_b (in_ch.operand_b),
    .entry     (entry)
  );

  assign in_ch.ready = !full;

  fpa_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_ch.valid),
    .push_entry (entry),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  fpa_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .pop        (pop),
    .out_ch     (out_ch)
  );
endmodule

// ----- rtl/fpa_checker.sv -----
// Port-level checks of the fixed-point ALU and their bind.
module fpa_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] result_value,
  input logic        a_greater,
  input logic        a_less,
  input logic        a_equal
);
  logic [7:0] pend_r;
  logic       in_fire, out_fire;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  // Count requests taken but not yet answered.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + {7'b0, in_fire} - {7'b0, out_fire};
    end
  end

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 8'd0) else $error("result without pending request");

  a_one_relation: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot({a_greater, a_less, a_equal}))
    else $error("comparison flags not exclusive");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped while stalled");

  a_hold_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(result_value))
    else $error("result changed while stalled");
endmodule

bind fixed_point_alu fpa_checker u_fpa_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .result_value (out_ch.result_value),
  .a_greater    (out_ch.a_greater),
  .a_less       (out_ch.a_less),
  .a_equal      (out_ch.a_equal)
);
